### sv/mpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes for the min priority queue cell array.
// ----------------------------------------------------------------------------
package mpq_pkg;

    localparam int DEPTH_DEF = 8;

    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] data_value;
        logic signed [31:0] priority_req;
    } mpq_in_t;

    typedef struct packed {
        logic signed [31:0] removed_data;
        logic signed [31:0] removed_priority;
        logic [1:0]         status;
        logic [3:0]         entries;
    } mpq_out_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic signed [31:0] prio;
    } mpq_entry_t;

    typedef struct packed {
        logic enq;
        logic deq;
    } mpq_ctrl_t;

endpackage

### sv/mpq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_cell
// One queue slot: holds an entry, forwards the running minimum token to the
// next cell and takes its right neighbor's entry when the gap closes.
// ----------------------------------------------------------------------------
module mpq_cell
    import mpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int IDX   = 0,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  mpq_ctrl_t        ctrl,
    input  logic [CNT_W-1:0] count,
    input  logic [IDX_W-1:0] best_idx,
    input  mpq_entry_t       enq_entry,
    input  mpq_entry_t       right_entry,
    input  logic             tin_v,
    input  mpq_entry_t       tin_entry,
    input  logic [IDX_W-1:0] tin_idx,
    output mpq_entry_t       own_entry,
    output logic             tout_v,
    output mpq_entry_t       tout_entry,
    output logic [IDX_W-1:0] tout_idx
);

    mpq_entry_t       entry_reg;
    logic             tok_v_reg;
    mpq_entry_t       tok_entry_reg;
    logic [IDX_W-1:0] tok_idx_reg;
    mpq_entry_t       tok_entry_next;
    logic [IDX_W-1:0] tok_idx_next;
    logic             own_valid;
    logic             take_own;

    assign own_valid = CNT_W'(IDX) < count;
    assign take_own  = own_valid &&
                       ((IDX == 0) || ($signed(entry_reg.prio) < $signed(tin_entry.prio)));

    always_comb begin
        if (take_own) begin
            tok_entry_next = entry_reg;
            tok_idx_next   = IDX_W'(IDX);
        end else begin
            tok_entry_next = tin_entry;
            tok_idx_next   = tin_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_v_reg <= 1'b0;
        end else begin
            tok_v_reg <= tin_v;
        end
    end

    always_ff @(posedge aclk) begin
        tok_entry_reg <= tok_entry_next;
        tok_idx_reg   <= tok_idx_next;
        if (ctrl.enq && (count == CNT_W'(IDX))) begin
            entry_reg <= enq_entry;
        end else if (ctrl.deq && (IDX_W'(IDX) >= best_idx)) begin
            entry_reg <= right_entry;
        end
    end

    assign own_entry  = entry_reg;
    assign tout_v     = tok_v_reg;
    assign tout_entry = tok_entry_reg;
    assign tout_idx   = tok_idx_reg;

endmodule

### sv/min_priority_queue_array_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_priority_queue_array_core
// Bounded min priority queue built as a chain of entry cells.
// ----------------------------------------------------------------------------
// Entries sit in insertion order, one per cell. An enqueue, and any request
// that reports full or empty, completes with its result appearing the cycle
// after acceptance. A dequeue on a non-empty queue holds the input off until
// its result is returned: a minimum token walks the cell chain one cell per
// clock, keeping the earliest entry on equal priorities, and when it leaves
// the last cell the winner is returned and the winner's cell and every later
// cell take their right neighbor's entry in the same clock. The entries field
// shows the count modulo 16.
module min_priority_queue_array_core
    import mpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  mpq_in_t  s_payload,
    output logic     m_valid,
    input  logic     m_ready,
    output mpq_out_t m_payload
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        IDLE,
        SCAN
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic             m_valid_reg;
    mpq_out_t         m_payload_reg;

    state_t           state_next;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_next;
    mpq_out_t         m_payload_next;

    mpq_ctrl_t        ctrl;
    mpq_entry_t       enq_entry;
    logic             accept;
    logic             start;
    logic             done;
    logic [CNT_W-1:0] count_dec;
    logic [CNT_W-1:0] count_inc;

    mpq_entry_t       own_entry  [DEPTH];
    logic             tout_v     [DEPTH];
    mpq_entry_t       tout_entry [DEPTH];
    logic [IDX_W-1:0] tout_idx   [DEPTH];

    assign s_ready   = (state_reg == IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign count_dec = count_reg - CNT_W'(1);
    assign count_inc = count_reg + CNT_W'(1);
    assign start     = accept && (s_payload.mode == MODE_DEQ) && (count_reg != '0);
    assign done      = (state_reg == SCAN) && tout_v[DEPTH-1];

    assign ctrl.enq  = accept && (s_payload.mode == MODE_ENQ) &&
                       (count_reg < CNT_W'(DEPTH));
    assign ctrl.deq  = done;
    assign enq_entry.data = s_payload.data_value;
    assign enq_entry.prio = s_payload.priority_req;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        mpq_entry_t       right_in;
        logic             tin_v;
        mpq_entry_t       tin_entry;
        logic [IDX_W-1:0] tin_idx;

        if (k == 0) begin : g_head
            assign tin_v     = start;
            assign tin_entry = '0;
            assign tin_idx   = '0;
        end else begin : g_body
            assign tin_v     = tout_v[k-1];
            assign tin_entry = tout_entry[k-1];
            assign tin_idx   = tout_idx[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign right_in = '0;
        end else begin : g_link
            assign right_in = own_entry[k+1];
        end

        mpq_cell #(
            .DEPTH (DEPTH),
            .IDX   (k)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .count       (count_reg),
            .best_idx    (tout_idx[DEPTH-1]),
            .enq_entry   (enq_entry),
            .right_entry (right_in),
            .tin_v       (tin_v),
            .tin_entry   (tin_entry),
            .tin_idx     (tin_idx),
            .own_entry   (own_entry[k]),
            .tout_v      (tout_v[k]),
            .tout_entry  (tout_entry[k]),
            .tout_idx    (tout_idx[k])
        );
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        unique case (state_reg)
            IDLE: begin
                if (accept) begin
                    m_valid_next                    = 1'b1;
                    m_payload_next.removed_data     = '0;
                    m_payload_next.removed_priority = '0;
                    m_payload_next.status           = ST_OK;
                    m_payload_next.entries          = 4'(count_reg);
                    if (s_payload.mode == MODE_ENQ) begin
                        if (ctrl.enq) begin
                            count_next             = count_inc;
                            m_payload_next.entries = 4'(count_inc);
                        end else begin
                            m_payload_next.status = ST_FULL;
                        end
                    end else if (start) begin
                        m_valid_next = 1'b0;
                        state_next   = SCAN;
                    end else begin
                        m_payload_next.status = ST_EMPTY;
                    end
                end
            end
            SCAN: begin
                if (done) begin
                    state_next                      = IDLE;
                    count_next                      = count_dec;
                    m_valid_next                    = 1'b1;
                    m_payload_next.removed_data     = tout_entry[DEPTH-1].data;
                    m_payload_next.removed_priority = tout_entry[DEPTH-1].prio;
                    m_payload_next.status           = ST_OK;
                    m_payload_next.entries          = 4'(count_dec);
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            m_valid_reg   <= m_valid_next;
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_scan_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == SCAN) |-> !m_valid_reg)
        else $error("result pending during search");

    a_start_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> (state_reg == SCAN))
        else $error("dequeue did not start search");

    a_deq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> (count_reg == $past(count_dec)) && m_valid_reg)
        else $error("dequeue did not remove one entry");
`endif

endmodule
